// File: design/lhls_pkg.sv
// Shared types, op and status codes, and register indexes for the lux light switch.
`default_nettype none
package lhls_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int SECS_W      = 12;

	// item opcodes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_CMD    = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_BAD_CHANNEL   = 2'd1;
	localparam logic [1:0] ST_BAD_COUNTDOWN = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AUTO       = 2'd2;

	// supported countdowns, seconds
	localparam logic [15:0] SECS_5MIN  = 16'd300;
	localparam logic [15:0] SECS_15MIN = 16'd900;
	localparam logic [15:0] SECS_30MIN = 16'd1800;
	localparam logic [15:0] SECS_60MIN = 16'd3600;

	typedef struct packed {
		logic [1:0]  op;
		logic [17:0] lux_q;
		logic        sample_valid;
		logic [3:0]  channel;
		logic        turn_on;
		logic [15:0] countdown_seconds;
	} item_t;

	typedef struct packed {
		logic [8:0] threshold_lux;
		logic [7:0] hysteresis_lux;
		logic       auto_enable;
	} cfg_t;

	// one-cycle update request to the channel bank
	typedef struct packed {
		logic              tick;
		logic              set_all;
		logic              all_on;
		logic              cmd_load;
		logic [3:0]        cmd_channel;
		logic              cmd_on;
		logic [SECS_W-1:0] cmd_secs;
	} chan_ctrl_t;

endpackage
`default_nettype wire

// File: design/lhls_cfg_regs.sv
// Configuration register file for the lux light switch.
`default_nettype none
module lhls_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [lhls_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  wire logic [lhls_pkg::CFG_DATA_W-1:0]    wr_data,
	output lhls_pkg::cfg_t                          cfg,
	output logic                                    auto_wr
);

	lhls_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_lux  <= 9'd50;
			cfg_q.hysteresis_lux <= 8'd10;
			cfg_q.auto_enable    <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				lhls_pkg::REG_THRESHOLD:  cfg_q.threshold_lux  <= wr_data[8:0];
				lhls_pkg::REG_HYSTERESIS: cfg_q.hysteresis_lux <= wr_data[7:0];
				lhls_pkg::REG_AUTO:       cfg_q.auto_enable    <= wr_data[0];
				default: ; // unknown index ignored
			endcase
		end
	end

	assign cfg     = cfg_q;
	assign auto_wr = wr_en && (wr_index == lhls_pkg::REG_AUTO);

endmodule
`default_nettype wire

// File: design/lhls_decode.sv
// Item decode: command checks, lux hysteresis decision and sensor/auto state.
`default_nettype none
module lhls_decode #(
	parameter int CHANNELS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire lhls_pkg::item_t    item,
	input  wire lhls_pkg::cfg_t     cfg,
	input  wire logic               auto_wr,
	output lhls_pkg::chan_ctrl_t    ctrl,
	output logic [1:0]              status_d,
	output logic                    healthy_d
);

	logic decided_q, last_q, healthy_q;
	logic decided_d, last_d;

	logic [10:0] on_below;
	logic [11:0] off_above;
	logic        want;
	logic        chan_ok, secs_ok;

	// thresholds in quarter lux
	assign on_below  = {cfg.threshold_lux, 2'b00};
	assign off_above = {({1'b0, cfg.threshold_lux} + {2'b00, cfg.hysteresis_lux}), 2'b00};

	always_comb begin
		if (item.lux_q < {7'd0, on_below})
			want = 1'b1;
		else if (item.lux_q > {6'd0, off_above})
			want = 1'b0;
		else
			want = decided_q && last_q;
	end

	assign chan_ok = ({1'b0, item.channel} < 5'(CHANNELS));
	assign secs_ok = (item.countdown_seconds == 16'd0) ||
	                 (item.countdown_seconds == lhls_pkg::SECS_5MIN) ||
	                 (item.countdown_seconds == lhls_pkg::SECS_15MIN) ||
	                 (item.countdown_seconds == lhls_pkg::SECS_30MIN) ||
	                 (item.countdown_seconds == lhls_pkg::SECS_60MIN);

	always_comb begin
		ctrl      = '0;
		status_d  = lhls_pkg::ST_OK;
		healthy_d = healthy_q;
		decided_d = decided_q;
		last_d    = last_q;
		if (fire) begin
			unique case (item.op)
				lhls_pkg::OP_TICK: ctrl.tick = 1'b1;
				lhls_pkg::OP_SAMPLE: begin
					if (cfg.auto_enable && healthy_q) begin
						if (!item.sample_valid) begin
							healthy_d = 1'b0; // latched until reset
						end else if (!decided_q || (want != last_q)) begin
							ctrl.set_all = 1'b1;
							ctrl.all_on  = want;
							last_d       = want;
							decided_d    = 1'b1;
						end
					end
				end
				lhls_pkg::OP_CMD: begin
					if (!chan_ok) begin
						status_d = lhls_pkg::ST_BAD_CHANNEL;
					end else if (!secs_ok) begin
						status_d = lhls_pkg::ST_BAD_COUNTDOWN;
					end else begin
						ctrl.cmd_load    = 1'b1;
						ctrl.cmd_channel = item.channel;
						ctrl.cmd_on      = item.turn_on;
						ctrl.cmd_secs    = item.countdown_seconds[lhls_pkg::SECS_W-1:0];
					end
				end
				default: ; // unused op
			endcase
		end
		if (auto_wr)
			decided_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decided_q <= 1'b0;
			last_q    <= 1'b0;
			healthy_q <= 1'b1;
		end else begin
			decided_q <= decided_d;
			last_q    <= last_d;
			healthy_q <= healthy_d;
		end
	end

endmodule
`default_nettype wire

// File: design/lhls_chan_bank.sv
// Per-channel lamp state and off-timer countdowns.
`default_nettype none
module lhls_chan_bank #(
	parameter int CHANNELS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lhls_pkg::chan_ctrl_t  ctrl,
	output logic [CHANNELS-1:0]        lamp_next
);

	logic [CHANNELS-1:0]             lamp_q;
	logic [lhls_pkg::SECS_W-1:0]     secs_q [CHANNELS];
	logic [lhls_pkg::SECS_W-1:0]     secs_d [CHANNELS];

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			lamp_next[i] = lamp_q[i];
			secs_d[i]    = secs_q[i];
			if (ctrl.tick && (secs_q[i] != '0)) begin
				secs_d[i] = secs_q[i] - 1'b1;
				if (secs_q[i] == lhls_pkg::SECS_W'(1))
					lamp_next[i] = 1'b0;
			end
			if (ctrl.set_all) begin
				lamp_next[i] = ctrl.all_on;
				secs_d[i]    = '0;
			end
			if (ctrl.cmd_load && (ctrl.cmd_channel == 4'(i))) begin
				lamp_next[i] = ctrl.cmd_on;
				secs_d[i]    = ctrl.cmd_secs;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q <= '0;
			for (int i = 0; i < CHANNELS; i++)
				secs_q[i] <= '0;
		end else begin
			lamp_q <= lamp_next;
			for (int i = 0; i < CHANNELS; i++)
				secs_q[i] <= secs_d[i];
		end
	end

endmodule
`default_nettype wire

// File: design/lux_hysteresis_light_switch.sv
// Top level of the multi-channel lux hysteresis light switch with off timers.
//
//  channel  handshake              payload
//  -------  ---------------------  ---------------------------------------------------
//  in       in_valid / in_ready    op, lux_q, sample_valid, channel, turn_on,
//                                  countdown_seconds
//  out      out_valid / out_ready  status, led_mask, sensor_ok
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// One item per cycle sustained while out_ready stays high; an input transaction passes
// the input register, then decode and channel update into the result register.
// All channels update in parallel in that single pass.
// Reset: lamps off, countdowns zero, sensor healthy, no auto decision, registers
// at threshold 50, hysteresis 10, auto off.
// Out stall: the result register holds; the input register still takes one item
// and in_ready drops only when both stages are full.
`default_nettype none
module lux_hysteresis_light_switch #(
	parameter int CHANNELS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// item channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         op,
	input  wire logic [17:0]                        lux_q,
	input  wire logic                               sample_valid,
	input  wire logic [3:0]                         channel,
	input  wire logic                               turn_on,
	input  wire logic [15:0]                        countdown_seconds,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [1:0]                              status,
	output logic [3:0]                              led_mask,
	output logic                                    sensor_ok,
	// configuration channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lhls_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [lhls_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// input stage
	lhls_pkg::item_t item_s1;
	logic            valid_s1;

	// result stage
	logic            valid_s2;
	logic [1:0]      status_s2;
	logic [3:0]      led_mask_s2;
	logic            sensor_ok_s2;

	logic                  fire;
	lhls_pkg::cfg_t        cfg;
	logic                  auto_wr;
	lhls_pkg::chan_ctrl_t  ctrl;
	logic [1:0]            status_d;
	logic                  healthy_d;
	logic [CHANNELS-1:0]   lamp_next;
	logic [3:0]            mask_d;

	// item in stage 1 moves to the result register when that register is empty or being read out
	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op                <= op;
			item_s1.lux_q             <= lux_q;
			item_s1.sample_valid      <= sample_valid;
			item_s1.channel           <= channel;
			item_s1.turn_on           <= turn_on;
			item_s1.countdown_seconds <= countdown_seconds;
		end
	end

	lhls_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.auto_wr  (auto_wr)
	);

	lhls_decode #(
		.CHANNELS (CHANNELS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.auto_wr   (auto_wr),
		.ctrl      (ctrl),
		.status_d  (status_d),
		.healthy_d (healthy_d)
	);

	lhls_chan_bank #(
		.CHANNELS (CHANNELS)
	) u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.lamp_next (lamp_next)
	);

	// mask shows channels 0..3 only; missing channels read as off
	for (genvar j = 0; j < 4; j++) begin : g_mask
		if (j < CHANNELS) begin : g_have
			assign mask_d[j] = lamp_next[j];
		end else begin : g_none
			assign mask_d[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2    <= status_d;
			led_mask_s2  <= mask_d;
			sensor_ok_s2 <= healthy_d;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign led_mask  = led_mask_s2;
	assign sensor_ok = sensor_ok_s2;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the lux hysteresis light switch: item stream, results, registers.
`default_nettype none
module tb_top;
	import lhls_pkg::*;

	// Geometry of the instance under test.
	localparam int NCH = 4;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 500;

	// Codes the package leaves out: the spare opcode and the unmapped register.
	localparam logic [1:0]             OP_UNUSED  = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] led_mask;
		logic       sensor_ok;
	} light_result_t;

	// Clock, reset (asserted from time zero), handshakes.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Item currently offered on the input channel; the payload ports are slices of it.
	item_t cur_item = '0;
	wire logic [1:0]  op = cur_item.op;
	wire logic [17:0] lux_q = cur_item.lux_q;
	wire logic        sample_valid = cur_item.sample_valid;
	wire logic [3:0]  channel = cur_item.channel;
	wire logic        turn_on = cur_item.turn_on;
	wire logic [15:0] countdown_seconds = cur_item.countdown_seconds;

	logic [1:0] status;
	logic [3:0] led_mask;
	logic       sensor_ok;

	lux_hysteresis_light_switch #(.CHANNELS(NCH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.lux_q(lux_q),
		.sample_valid(sample_valid),
		.channel(channel),
		.turn_on(turn_on),
		.countdown_seconds(countdown_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.led_mask(led_mask),
		.sensor_ok(sensor_ok),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the switch: registers and per-channel state.
	// Starts at reset values; reset is applied only once.
	// ------------------------------------------------------------------
	logic [8:0]        thr_reg = 9'd50;
	logic [7:0]        hyst_reg = 8'd10;
	logic              auto_reg = 1'b0;
	logic              lamp [NCH] = '{default: 1'b0};
	logic [SECS_W-1:0] secs_left [NCH] = '{default: '0};
	logic              decided = 1'b0;
	logic              last_on = 1'b0;
	logic              healthy = 1'b1;

	item_t         item_backlog [$];
	light_result_t awaited_results [$];
	int            queued_cnt = 0;
	int            accepted_cnt = 0;
	int            failures = 0;
	int            in_gap = 0;
	int            out_gap = 0;
	int            stalled_cycles = 0;
	bit            no_idle = 1'b0;

	task automatic note_failure(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		failures++;
	endtask

	// Applies one item to the shadow state and returns the result it should produce.
	function automatic light_result_t advance_switch(input item_t it);
		light_result_t r;
		logic want;
		int on_below;
		int off_above;
		int c;
		r = '0;
		r.status = ST_OK;
		case (it.op)
		OP_TICK: begin
			// every running countdown steps down; reaching zero turns the lamp off
			for (c = 0; c < NCH; c++) begin
				if (secs_left[c] != '0) begin
					secs_left[c] = secs_left[c] - 1'b1;
					if (secs_left[c] == '0)
						lamp[c] = 1'b0;
				end
			end
		end
		OP_SAMPLE: begin
			// only looked at in auto mode with a healthy sensor
			if (auto_reg && healthy) begin
				if (!it.sample_valid) begin
					healthy = 1'b0;  // sticky until reset
				end else begin
					on_below = int'(thr_reg) * 4;
					off_above = (int'(thr_reg) + int'(hyst_reg)) * 4;
					want = decided ? last_on : 1'b0;
					if (int'(it.lux_q) < on_below)
						want = 1'b1;
					else if (int'(it.lux_q) > off_above)
						want = 1'b0;
					// first decision or a change: all lamps follow, timers cleared
					if (!decided || want != last_on) begin
						for (c = 0; c < NCH; c++) begin
							lamp[c] = want;
							secs_left[c] = '0;
						end
						last_on = want;
						decided = 1'b1;
					end
				end
			end
		end
		OP_CMD: begin
			if (it.channel >= NCH) begin
				r.status = ST_BAD_CHANNEL;
			end else if (!(it.countdown_seconds == '0 || it.countdown_seconds == SECS_5MIN
					|| it.countdown_seconds == SECS_15MIN || it.countdown_seconds == SECS_30MIN
					|| it.countdown_seconds == SECS_60MIN)) begin
				r.status = ST_BAD_COUNTDOWN;
			end else begin
				lamp[it.channel] = it.turn_on;
				secs_left[it.channel] = it.countdown_seconds[SECS_W-1:0];
			end
		end
		default: ;  // spare opcode: no effect
		endcase
		for (c = 0; c < NCH; c++)
			r.led_mask[c] = lamp[c];
		r.sensor_ok = healthy;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers backlog items, predicts on each input transaction.
	// Random idle gaps are inserted between items unless no_idle is set.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			awaited_results.push_back(advance_switch(cur_item));
			accepted_cnt++;
		end
		if (!in_valid || in_ready) begin
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (item_backlog.size() != 0) begin
				cur_item <= item_backlog.pop_front();
				in_valid <= 1'b1;
				if (!no_idle && $urandom_range(0, 11) == 0)
					in_gap = $urandom_range(1, 7);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random backpressure bursts; every output transaction is
	// checked field by field against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		light_result_t exp_r;
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("result with nothing pending: status %0d mask %h ok %0d",
					status, led_mask, sensor_ok));
			end else begin
				exp_r = awaited_results.pop_front();
				if (status !== exp_r.status)
					note_failure($sformatf("status %0d, expected %0d", status, exp_r.status));
				if (led_mask !== exp_r.led_mask)
					note_failure($sformatf("led_mask %h, expected %h", led_mask, exp_r.led_mask));
				if (sensor_ok !== exp_r.sensor_ok)
					note_failure($sformatf("sensor_ok %0d, expected %0d", sensor_ok,
						exp_r.sensor_ok));
			end
		end
		if (out_gap != 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 9) == 0)
				out_gap = $urandom_range(1, 7);
		end
	end

	// Watchdog: any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic item_t make_item(input logic [1:0] op_code, input logic [17:0] lux,
			input logic valid, input logic [3:0] ch, input logic on, input logic [15:0] secs);
		item_t it;
		it.op = op_code;
		it.lux_q = lux;
		it.sample_valid = valid;
		it.channel = ch;
		it.turn_on = on;
		it.countdown_seconds = secs;
		return it;
	endfunction

	function automatic void queue_item(input item_t it);
		item_backlog.push_back(it);
		queued_cnt++;
	endfunction

	// Lux mostly clustered around the two switching points, sometimes anywhere.
	function automatic logic [17:0] pick_lux();
		int base;
		int v;
		case ($urandom_range(0, 9))
		0, 1:       return 18'($urandom());
		2, 3, 4, 5: base = int'(thr_reg) * 4;
		default:    base = (int'(thr_reg) + int'(hyst_reg)) * 4;
		endcase
		v = base + int'($urandom_range(0, 12)) - 6;
		if (v < 0)
			v = 0;
		return v[17:0];
	endfunction

	function automatic logic [15:0] pick_countdown();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom());
		case ($urandom_range(0, 4))
		0:       return '0;
		1:       return SECS_5MIN;
		2:       return SECS_15MIN;
		3:       return SECS_30MIN;
		default: return SECS_60MIN;
		endcase
	endfunction

	// may_fail allows invalid samples while auto mode is on (kills the sensor for good).
	function automatic item_t random_item(input bit may_fail);
		item_t it;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			it.op = OP_UNUSED;
		else if (r <= 5)
			it.op = OP_TICK;
		else if (r <= 13)
			it.op = OP_SAMPLE;
		else
			it.op = OP_CMD;
		it.lux_q = pick_lux();
		if (may_fail)
			it.sample_valid = ($urandom_range(0, 19) != 0);
		else if (!auto_reg)
			it.sample_valid = 1'($urandom_range(0, 1));
		else
			it.sample_valid = 1'b1;
		it.channel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, NCH - 1));
		it.turn_on = 1'($urandom_range(0, 1));
		it.countdown_seconds = pick_countdown();
		return it;
	endfunction

	// One register write; shadow registers follow on the handshake.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_THRESHOLD:  thr_reg = data[8:0];
		REG_HYSTERESIS: hyst_reg = data[7:0];
		REG_AUTO: begin
			auto_reg = data[0];
			decided = 1'b0;  // any write drops the latched decision
		end
		default: ;  // unmapped index: ignored
		endcase
	endtask

	// Wait until every queued item went in and every result came out, then let the pipe settle.
	task automatic drain();
		while (accepted_cnt != queued_cnt || awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [8:0] thr, input logic [7:0] hyst, input logic auto_on);
		drain();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_HYSTERESIS, {1'($urandom_range(0, 1)), hyst});
		write_reg(REG_AUTO, {8'($urandom()), auto_on});
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int i;
		item_t it;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (auto off): timers, bad commands, spare op, ignored samples.
		queue_item(make_item(OP_TICK, '0, 1'b0, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd0, 1'b1, SECS_5MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd1, 1'b1, SECS_15MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd2, 1'b1, SECS_30MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd3, 1'b1, SECS_60MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd15, 1'b1, '0));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd4, 1'b1, SECS_5MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd0, 1'b0, 16'd301));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd0, 1'b1, 16'hFFFF));
		queue_item(make_item(OP_UNUSED, '1, 1'b1, 4'hF, 1'b1, 16'hFFFF));
		queue_item(make_item(OP_SAMPLE, '0, 1'b1, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_SAMPLE, 18'd100, 1'b0, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_TICK, '0, 1'b0, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd3, 1'b0, '0));

		// Directed, auto on at 50/10 lux: edges of both switching points and a timer wipe.
		reconfigure(9'd50, 8'd10, 1'b1);
		queue_item(make_item(OP_SAMPLE, 18'd200, 1'b1, 4'd0, 1'b0, '0));    // at on point
		queue_item(make_item(OP_SAMPLE, 18'd199, 1'b1, 4'd0, 1'b0, '0));    // just below
		queue_item(make_item(OP_SAMPLE, 18'd240, 1'b1, 4'd0, 1'b0, '0));    // at off point
		queue_item(make_item(OP_SAMPLE, 18'd241, 1'b1, 4'd0, 1'b0, '0));    // just above
		queue_item(make_item(OP_SAMPLE, 18'd220, 1'b1, 4'd0, 1'b0, '0));    // dead band
		queue_item(make_item(OP_SAMPLE, 18'd0, 1'b1, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_CMD, '0, 1'b1, 4'd2, 1'b0, SECS_5MIN));
		queue_item(make_item(OP_SAMPLE, 18'h3FFFF, 1'b1, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_TICK, '0, 1'b1, 4'd0, 1'b0, '0));
		queue_item(make_item(OP_UNUSED, '0, 1'b0, 4'd0, 1'b0, '0));

		// Random phases at the register extremes; threshold 0 and 511 are taken as written.
		reconfigure(9'd5, 8'd0, 1'b1);
		for (i = 0; i < 110; i++)
			queue_item(random_item(1'b0));
		reconfigure(9'd300, 8'd255, 1'b1);
		for (i = 0; i < 110; i++)
			queue_item(random_item(1'b0));
		reconfigure(9'd0, 8'($urandom_range(0, 255)), 1'b1);
		for (i = 0; i < 45; i++)
			queue_item(random_item(1'b0));
		drain();
		write_reg(REG_UNUSED, 9'h1FF);
		cfg_valid <= 1'b0;
		reconfigure(9'd511, 8'd255, 1'b1);
		for (i = 0; i < 45; i++)
			queue_item(random_item(1'b0));

		// Timer run, auto off: load countdowns, then mostly ticks so short timers expire.
		reconfigure(9'($urandom_range(5, 300)), 8'($urandom_range(0, 255)), 1'b0);
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd0, 1'b1, SECS_5MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd1, 1'b1, SECS_5MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd2, 1'b1, SECS_15MIN));
		queue_item(make_item(OP_CMD, '0, 1'b0, 4'd3, 1'b0, SECS_30MIN));
		for (i = 0; i < 330; i++) begin
			it = random_item(1'b0);
			if ($urandom_range(0, 19) != 0)
				it.op = OP_TICK;
			else if (it.op == OP_CMD && it.channel == 4'd0)
				it.channel = 4'd1;  // keep channel 0 counting down undisturbed
			queue_item(it);
		end

		// Last part: no idling, auto on, invalid samples allowed (sensor failure latches).
		no_idle = 1'b1;
		reconfigure(9'($urandom_range(5, 300)), 8'($urandom_range(0, 255)), 1'b1);
		for (i = 0; i < 70; i++)
			queue_item(random_item(1'b1));

		drain();
		repeat (6) @(posedge clk);
		if (failures == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
